// ===== src/plane_segment_and_point_query_assert.svh =====
// assertion macros for the plane segment and point query block
// expects clk and arst_n in the scope of each use
`ifndef PLANE_SEGMENT_AND_POINT_QUERY_ASSERT_SVH
`define PLANE_SEGMENT_AND_POINT_QUERY_ASSERT_SVH
`ifndef SYNTH
`define PSQ_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("psq assertion failed");
`define PSQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("psq assertion failed");
`else
`define PSQ_ASSERT_IMPL(lbl, ante, cons)
`define PSQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/psq_pkg.sv =====
// types, constants and helpers shared by the plane query block
// no dependencies
package psq_pkg;

	localparam int COORD_BITS = 32;
	localparam int SAT_BITS   = (COORD_BITS > 32) ? 32 : COORD_BITS;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int DIV_STEPS  = 32;
	localparam int SUM_W      = 51;

	localparam logic signed [SUM_W-1:0] SAT_HI =
		$signed({{(SUM_W-SAT_BITS+1){1'b0}}, {(SAT_BITS-1){1'b1}}});
	localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

	typedef enum logic [2:0] {
		ST_WITHIN   = 3'd0,
		ST_OUTSIDE  = 3'd1,
		ST_PARALLEL = 3'd2,
		ST_ON       = 3'd3,
		ST_ABOVE    = 3'd4,
		ST_BELOW    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		REG_PLANE_X  = 3'd0,
		REG_PLANE_Y  = 3'd1,
		REG_PLANE_Z  = 3'd2,
		REG_NORMAL_X = 3'd3,
		REG_NORMAL_Y = 3'd4,
		REG_NORMAL_Z = 3'd5,
		REG_TOL      = 3'd6
	} reg_idx_t;

	localparam logic OP_SEGMENT = 1'b0;

	typedef struct packed {
		logic               opcode;
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] first_z;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
		logic signed [31:0] second_z;
	} in_t;

	typedef struct packed {
		logic signed [31:0] result_x;
		logic signed [31:0] result_y;
		logic signed [31:0] result_z;
		logic signed [31:0] segment_param;
		logic [2:0]         status;
	} out_t;

	typedef struct packed {
		logic signed [31:0] plane_x;
		logic signed [31:0] plane_y;
		logic signed [31:0] plane_z;
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic [30:0]        tolerance;
	} cfg_t;

	// front to back queue entry
	typedef struct packed {
		logic               op;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [32:0] dz;
		logic signed [36:0] num;
		logic signed [36:0] den;
	} fe_t;

	// payload carried beside the divider
	typedef struct packed {
		logic               op;
		status_t            cls;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [32:0] dz;
		logic signed [36:0] dp;
		logic               ovf;
		logic               negq;
	} dv_t;

	typedef struct packed {
		logic               op;
		status_t            cls;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [31:0] u;
		logic signed [36:0] ma;
		logic signed [32:0] mbx;
		logic signed [32:0] mby;
		logic signed [32:0] mbz;
	} fx_t;

	function automatic logic signed [31:0] sat_coord(input logic signed [SUM_W-1:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[31:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[31:0];
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== src/plane_segment_and_point_query.sv =====
// top level of the plane segment and point query block
// depends on psq_pkg, psq_front, psq_fifo, psq_back
//
// Queries against a fixed plane held in seven configuration registers
// (plane point, normal, tolerance) written through cfg_we/cfg_addr/cfg_wdata.
// Input items arrive on in_valid/in_ready/in_data; opcode 0 intersects the
// segment first-second with the plane, opcode 1 classifies and projects the
// point first. Each item gives one result on out_valid/out_ready/out_data.
// Throughput is one item per cycle while out_ready keeps the back end moving.
// From input transfer to result an item passes three front stages (differences,
// products, dot sums), the queue, a prep stage, 32 divider stages (one
// quotient bit each), then sign fix, multiply and output stages.
// When the receiver stalls the back end holds; the four-entry queue absorbs
// the front end until full, then in_ready drops. Reset clears all valid
// state and loads the register reset values (normal z one, tolerance one).
module plane_segment_and_point_query (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  psq_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output psq_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_addr,
	input  logic [31:0]   cfg_wdata
);

	psq_pkg::cfg_t cfg_q;
	logic          fifo_full, fifo_empty, push, pop;
	psq_pkg::fe_t  push_data, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.plane_x   <= '0;
			cfg_q.plane_y   <= '0;
			cfg_q.plane_z   <= '0;
			cfg_q.normal_x  <= '0;
			cfg_q.normal_y  <= '0;
			cfg_q.normal_z  <= 32'sh4000_0000;
			cfg_q.tolerance <= 31'd1;
		end else if (cfg_we) begin
			unique case (psq_pkg::reg_idx_t'(cfg_addr))
				psq_pkg::REG_PLANE_X:  cfg_q.plane_x   <= cfg_wdata;
				psq_pkg::REG_PLANE_Y:  cfg_q.plane_y   <= cfg_wdata;
				psq_pkg::REG_PLANE_Z:  cfg_q.plane_z   <= cfg_wdata;
				psq_pkg::REG_NORMAL_X: cfg_q.normal_x  <= cfg_wdata;
				psq_pkg::REG_NORMAL_Y: cfg_q.normal_y  <= cfg_wdata;
				psq_pkg::REG_NORMAL_Z: cfg_q.normal_z  <= cfg_wdata;
				psq_pkg::REG_TOL:      cfg_q.tolerance <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	psq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.fifo_full (fifo_full),
		.push      (push),
		.push_data (push_data)
	);

	psq_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (fifo_full),
		.empty     (fifo_empty)
	);

	psq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.empty     (fifo_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== src/psq_front.sv =====
// front end: differences, dot product products and sums
// depends on psq_pkg
module psq_front (
	input  logic           clk,
	input  logic           arst_n,
	input  psq_pkg::cfg_t  cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  psq_pkg::in_t   in_data,
	input  logic           fifo_full,
	output logic           push,
	output psq_pkg::fe_t   push_data
);

	logic front_en;

	logic               v_s1, op_s1;
	logic signed [31:0] ax_s1, ay_s1, az_s1;
	logic signed [32:0] nx_s1, ny_s1, nz_s1;
	logic signed [32:0] dx_s1, dy_s1, dz_s1;

	logic               v_s2, op_s2;
	logic signed [31:0] ax_s2, ay_s2, az_s2;
	logic signed [32:0] dx_s2, dy_s2, dz_s2;
	logic signed [64:0] pnx_s2, pny_s2, pnz_s2, pdx_s2, pdy_s2, pdz_s2;

	logic               v_s3;
	psq_pkg::fe_t       fe_s3;

	logic signed [32:0] ax33, ay33, az33, px33, py33, pz33;
	logic signed [66:0] sum_n, sum_d;

	assign front_en = !(v_s3 && fifo_full);
	assign in_ready = front_en;

	assign ax33 = 33'(in_data.first_x);
	assign ay33 = 33'(in_data.first_y);
	assign az33 = 33'(in_data.first_z);
	assign px33 = 33'(cfg.plane_x);
	assign py33 = 33'(cfg.plane_y);
	assign pz33 = 33'(cfg.plane_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (front_en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (front_en) begin
			op_s1 <= in_data.opcode;
			ax_s1 <= in_data.first_x;
			ay_s1 <= in_data.first_y;
			az_s1 <= in_data.first_z;
			if (in_data.opcode == psq_pkg::OP_SEGMENT) begin
				nx_s1 <= px33 - ax33;
				ny_s1 <= py33 - ay33;
				nz_s1 <= pz33 - az33;
			end else begin
				nx_s1 <= ax33 - px33;
				ny_s1 <= ay33 - py33;
				nz_s1 <= az33 - pz33;
			end
			dx_s1 <= 33'(in_data.second_x) - ax33;
			dy_s1 <= 33'(in_data.second_y) - ay33;
			dz_s1 <= 33'(in_data.second_z) - az33;
		end
	end

	always_ff @(posedge clk) begin
		if (front_en) begin
			op_s2  <= op_s1;
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			az_s2  <= az_s1;
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			dz_s2  <= dz_s1;
			pnx_s2 <= nx_s1 * cfg.normal_x;
			pny_s2 <= ny_s1 * cfg.normal_y;
			pnz_s2 <= nz_s1 * cfg.normal_z;
			pdx_s2 <= dx_s1 * cfg.normal_x;
			pdy_s2 <= dy_s1 * cfg.normal_y;
			pdz_s2 <= dz_s1 * cfg.normal_z;
		end
	end

	always_comb begin
		sum_n = 67'(pnx_s2) + 67'(pny_s2) + 67'(pnz_s2);
		sum_d = 67'(pdx_s2) + 67'(pdy_s2) + 67'(pdz_s2);
	end

	always_ff @(posedge clk) begin
		if (front_en) begin
			fe_s3.op  <= op_s2;
			fe_s3.ax  <= ax_s2;
			fe_s3.ay  <= ay_s2;
			fe_s3.az  <= az_s2;
			fe_s3.dx  <= dx_s2;
			fe_s3.dy  <= dy_s2;
			fe_s3.dz  <= dz_s2;
			fe_s3.num <= sum_n[66:30];
			fe_s3.den <= sum_d[66:30];
		end
	end

	assign push      = v_s3 && !fifo_full;
	assign push_data = fe_s3;

endmodule

// ===== src/psq_fifo.sv =====
// short queue between front and back ends
// depends on psq_pkg and the assertion macro header
`include "plane_segment_and_point_query_assert.svh"
module psq_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  psq_pkg::fe_t  push_data,
	input  logic          pop,
	output psq_pkg::fe_t  head,
	output logic          full,
	output logic          empty
);

	localparam int DEPTH = psq_pkg::FIFO_DEPTH;
	localparam int AW    = psq_pkg::FIFO_AW;
	localparam int CNT_W = $clog2(DEPTH + 1);

	psq_pkg::fe_t     mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	`PSQ_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(DEPTH))
	`PSQ_ASSERT_IMPL(a_no_pop_empty, cnt_q == '0, !pop)
	`PSQ_ASSERT_IMPL(a_no_push_full, cnt_q == CNT_W'(DEPTH), !push)
	`PSQ_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_q == CNT_W'($past(cnt_q) + 1'b1))

endmodule

// ===== src/psq_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on psq_pkg
module psq_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  psq_pkg::dv_t  in_pl,
	input  logic [37:0]   in_rem,
	input  logic [31:0]   in_low,
	input  logic [36:0]   in_den,
	output logic          out_v,
	output psq_pkg::dv_t  out_pl,
	output logic [31:0]   out_q
);

	localparam int N = psq_pkg::DIV_STEPS;

	logic          vld_s [N];
	psq_pkg::dv_t  pl_s  [N];
	logic [37:0]   r_s   [N];
	logic [31:0]   n_s   [N];
	logic [36:0]   d_s   [N];
	logic [31:0]   q_s   [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		logic          v_in;
		psq_pkg::dv_t  p_in;
		logic [37:0]   r_in, t;
		logic [31:0]   n_in, q_in;
		logic [36:0]   d_in;

		if (k == 0) begin : g_first
			assign v_in = in_v;
			assign p_in = in_pl;
			assign r_in = in_rem;
			assign n_in = in_low;
			assign d_in = in_den;
			assign q_in = '0;
		end else begin : g_next
			assign v_in = vld_s[k-1];
			assign p_in = pl_s[k-1];
			assign r_in = r_s[k-1];
			assign n_in = n_s[k-1];
			assign d_in = d_s[k-1];
			assign q_in = q_s[k-1];
		end

		assign t = {r_in[36:0], n_in[31]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (t >= {1'b0, d_in}) begin
					r_s[k] <= t - {1'b0, d_in};
					q_s[k] <= {q_in[30:0], 1'b1};
				end else begin
					r_s[k] <= t;
					q_s[k] <= {q_in[30:0], 1'b0};
				end
				n_s[k]  <= {n_in[30:0], 1'b0};
				d_s[k]  <= d_in;
				pl_s[k] <= p_in;
			end
		end
	end

	assign out_v  = vld_s[N-1];
	assign out_pl = pl_s[N-1];
	assign out_q  = q_s[N-1];

endmodule

// ===== src/psq_back.sv =====
// back end: classification, division, scaling and output register
// depends on psq_pkg and psq_div
module psq_back (
	input  logic          clk,
	input  logic          arst_n,
	input  psq_pkg::cfg_t cfg,
	input  logic          empty,
	input  psq_pkg::fe_t  head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output psq_pkg::out_t out_data
);

	logic back_en;

	// prep
	logic [36:0]   abs_num, abs_den;
	psq_pkg::dv_t  prep;

	logic          v_b1;
	psq_pkg::dv_t  dv_b1;
	logic [37:0]   r_b1;
	logic [31:0]   n_b1;
	logic [36:0]   d_b1;

	logic          dv_v;
	psq_pkg::dv_t  dv_pl;
	logic [31:0]   dv_q;

	psq_pkg::fx_t  fix;
	logic          v_fx;
	psq_pkg::fx_t  fx_s;

	logic               v_mul;
	psq_pkg::fx_t       fx_mul;
	logic signed [69:0] px_mul, py_mul, pz_mul;

	psq_pkg::out_t      res;
	logic               v_out_q;
	psq_pkg::out_t      out_q;

	assign back_en = !v_out_q || out_ready;
	assign pop     = !empty && back_en;

	always_comb begin
		abs_num   = head.num[36] ? 37'(-head.num) : 37'(head.num);
		abs_den   = head.den[36] ? 37'(-head.den) : 37'(head.den);
		prep.op   = head.op;
		prep.ax   = head.ax;
		prep.ay   = head.ay;
		prep.az   = head.az;
		prep.dx   = head.dx;
		prep.dy   = head.dy;
		prep.dz   = head.dz;
		prep.dp   = head.num;
		prep.ovf  = ({16'b0, abs_num[36:16]} >= abs_den);
		prep.negq = head.num[36] ^ head.den[36];
		if (head.op == psq_pkg::OP_SEGMENT) begin
			prep.cls = (abs_den <= {6'b0, cfg.tolerance}) ? psq_pkg::ST_PARALLEL
				: psq_pkg::ST_WITHIN;
		end else if (abs_num <= {6'b0, cfg.tolerance}) begin
			prep.cls = psq_pkg::ST_ON;
		end else begin
			prep.cls = head.num[36] ? psq_pkg::ST_BELOW : psq_pkg::ST_ABOVE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1    <= 1'b0;
			v_fx    <= 1'b0;
			v_mul   <= 1'b0;
			v_out_q <= 1'b0;
		end else if (back_en) begin
			v_b1    <= pop;
			v_fx    <= dv_v;
			v_mul   <= v_fx;
			v_out_q <= v_mul;
		end
	end

	always_ff @(posedge clk) begin
		if (back_en) begin
			dv_b1 <= prep;
			r_b1  <= {17'b0, abs_num[36:16]};
			n_b1  <= {abs_num[15:0], 16'b0};
			d_b1  <= abs_den;
		end
	end

	psq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (back_en),
		.in_v   (v_b1),
		.in_pl  (dv_b1),
		.in_rem (r_b1),
		.in_low (n_b1),
		.in_den (d_b1),
		.out_v  (dv_v),
		.out_pl (dv_pl),
		.out_q  (dv_q)
	);

	// quotient sign, saturation and bound test
	always_comb begin
		logic signed [31:0] uq;
		logic signed [33:0] u34, tol34;
		if (dv_pl.ovf) begin
			uq = dv_pl.negq ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else if (dv_pl.negq) begin
			uq = (dv_q > 32'h8000_0000) ? 32'sh8000_0000 : $signed(-dv_q);
		end else begin
			uq = dv_q[31] ? 32'sh7fff_ffff : $signed(dv_q);
		end
		u34   = 34'(uq);
		tol34 = $signed({3'b000, cfg.tolerance});
		fix.op  = dv_pl.op;
		fix.ax  = dv_pl.ax;
		fix.ay  = dv_pl.ay;
		fix.az  = dv_pl.az;
		fix.cls = dv_pl.cls;
		fix.u   = '0;
		if (dv_pl.op == psq_pkg::OP_SEGMENT) begin
			fix.ma  = 37'(uq);
			fix.mbx = dv_pl.dx;
			fix.mby = dv_pl.dy;
			fix.mbz = dv_pl.dz;
			if (dv_pl.cls != psq_pkg::ST_PARALLEL) begin
				fix.u = uq;
				fix.cls = (u34 >= -tol34 && u34 <= 34'sd65536 + tol34)
					? psq_pkg::ST_WITHIN : psq_pkg::ST_OUTSIDE;
			end
		end else begin
			fix.ma  = dv_pl.dp;
			fix.mbx = 33'(cfg.normal_x);
			fix.mby = 33'(cfg.normal_y);
			fix.mbz = 33'(cfg.normal_z);
		end
	end

	always_ff @(posedge clk) begin
		if (back_en) begin
			fx_s   <= fix;
			fx_mul <= fx_s;
			px_mul <= fx_s.ma * fx_s.mbx;
			py_mul <= fx_s.ma * fx_s.mby;
			pz_mul <= fx_s.ma * fx_s.mbz;
		end
	end

	always_comb begin
		logic signed [psq_pkg::SUM_W-1:0] sx, sy, sz, ex, ey, ez;
		if (fx_mul.op == psq_pkg::OP_SEGMENT) begin
			sx = psq_pkg::SUM_W'(px_mul >>> 16);
			sy = psq_pkg::SUM_W'(py_mul >>> 16);
			sz = psq_pkg::SUM_W'(pz_mul >>> 16);
			ex = psq_pkg::SUM_W'(fx_mul.ax) + sx;
			ey = psq_pkg::SUM_W'(fx_mul.ay) + sy;
			ez = psq_pkg::SUM_W'(fx_mul.az) + sz;
		end else begin
			sx = psq_pkg::SUM_W'(px_mul >>> 30);
			sy = psq_pkg::SUM_W'(py_mul >>> 30);
			sz = psq_pkg::SUM_W'(pz_mul >>> 30);
			ex = psq_pkg::SUM_W'(fx_mul.ax) - sx;
			ey = psq_pkg::SUM_W'(fx_mul.ay) - sy;
			ez = psq_pkg::SUM_W'(fx_mul.az) - sz;
		end
		res.segment_param = fx_mul.u;
		res.status        = fx_mul.cls;
		unique case (fx_mul.cls)
			psq_pkg::ST_PARALLEL: begin
				res.result_x = '0;
				res.result_y = '0;
				res.result_z = '0;
			end
			psq_pkg::ST_ON: begin
				res.result_x = fx_mul.ax;
				res.result_y = fx_mul.ay;
				res.result_z = fx_mul.az;
			end
			default: begin
				res.result_x = psq_pkg::sat_coord(ex);
				res.result_y = psq_pkg::sat_coord(ey);
				res.result_z = psq_pkg::sat_coord(ez);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (back_en) begin
			out_q <= res;
		end
	end

	assign out_valid = v_out_q;
	assign out_data  = out_q;

endmodule
